FILE: hdl/tls_record_header_parser_assert.svh
// Assertion macros shared by the TLS record header parser RTL.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef TLS_RECORD_HEADER_PARSER_ASSERT_SVH
`define TLS_RECORD_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRHP_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TRHP_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/trhp_pkg.sv
// Shared types and constants for the TLS record header parser.
// No dependencies; imported by trhp_core and tls_record_header_parser.
`default_nettype none

package trhp_pkg;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MORE = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	localparam int unsigned HDR_BYTES = 5;

	localparam logic [7:0] TYPE_MIN  = 8'd20;
	localparam logic [7:0] TYPE_MAX  = 8'd23;
	localparam logic [7:0] VER_MAJOR = 8'd3;
	localparam logic [7:0] MINOR_MIN = 8'd1;
	localparam logic [7:0] MINOR_MAX = 8'd3;

	// 16384 plaintext bytes plus 2048 of expansion
	localparam logic [15:0] MAX_FRAG_RST = 16'd18432;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  content_type;
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
		logic [15:0] fragment_length;
		logic [16:0] bytes_consumed;
	} trhp_result_t;

endpackage

`default_nettype wire

FILE: hdl/trhp_core.sv
// Parser state and per-byte decision logic for the TLS record header parser.
// Depends on trhp_pkg and tls_record_header_parser_assert.svh.
`default_nettype none

module trhp_core
	import trhp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   data_byte,
	input  wire logic         last_byte,
	input  wire logic [15:0]  max_len,
	output trhp_result_t      res,
	output logic              res_fire
);

`include "tls_record_header_parser_assert.svh"

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;

	localparam logic [2:0] HDR_LAST = 3'(HDR_BYTES - 1);

	logic [1:0]  phase_q, phase_d;
	logic [2:0]  hidx_q, hidx_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  major_q, major_d;
	logic [7:0]  minor_q, minor_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] cnt_inc;
	logic [1:0]  st;
	logic        full;
	logic        hdr_bad;

	assign cnt_inc = cnt_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		hidx_d   = hidx_q;
		type_d   = type_q;
		major_d  = major_q;
		minor_d  = minor_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		res_fire = 1'b0;
		st       = ST_OK;
		full     = 1'b0;
		hdr_bad  = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				case (hidx_q)
					3'd0: type_d = data_byte;
					3'd1: major_d = data_byte;
					3'd2: minor_d = data_byte;
					3'd3: len_d = {data_byte, 8'h00};
					default: len_d = {len_q[15:8], data_byte};
				endcase
				hidx_d = hidx_q + 3'd1;
				if (hidx_q < HDR_LAST) begin
					if (last_byte) begin
						res_fire = 1'b1;
						st       = ST_MORE;
						phase_d  = PH_HEADER;
						hidx_d   = '0;
						cnt_d    = '0;
					end
				end else begin
					// checks in order: type, version, length
					hdr_bad = !(type_d inside {[TYPE_MIN:TYPE_MAX]}) ||
					          (major_d != VER_MAJOR) ||
					          !(minor_d inside {[MINOR_MIN:MINOR_MAX]}) ||
					          (len_d > max_len);
					hidx_d = '0;
					cnt_d  = '0;
					if (hdr_bad || len_d == 16'd0) begin
						res_fire = 1'b1;
						st       = hdr_bad ? ST_BAD : ST_OK;
						full     = !hdr_bad;
						phase_d  = last_byte ? PH_HEADER : PH_SKIP;
					end else if (last_byte) begin
						res_fire = 1'b1;
						st       = ST_MORE;
						phase_d  = PH_HEADER;
					end else begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				cnt_d = cnt_inc;
				if (cnt_inc == len_q) begin
					res_fire = 1'b1;
					st       = ST_OK;
					full     = 1'b1;
					if (last_byte) begin
						phase_d = PH_HEADER;
						hidx_d  = '0;
						cnt_d   = '0;
					end else begin
						phase_d = PH_SKIP;
					end
				end else if (last_byte) begin
					res_fire = 1'b1;
					st       = ST_MORE;
					phase_d  = PH_HEADER;
					hidx_d   = '0;
					cnt_d    = '0;
				end
			end
			default: begin
				// skip rest of buffer; unused code behaves the same
				if (last_byte) begin
					phase_d = PH_HEADER;
					hidx_d  = '0;
					cnt_d   = '0;
				end
			end
		endcase
	end

	always_comb begin
		res.status          = st;
		res.content_type    = full ? type_d : 8'd0;
		res.version_major   = full ? major_d : 8'd0;
		res.version_minor   = full ? minor_d : 8'd0;
		res.fragment_length = full ? len_d : 16'd0;
		res.bytes_consumed  = full ? ({1'b0, len_d} + 17'(HDR_BYTES)) : 17'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q  <= '0;
			type_q  <= '0;
			major_q <= '0;
			minor_q <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			type_q  <= type_d;
			major_q <= major_d;
			minor_q <= minor_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

	`TRHP_ASSERT_NXT(a_last_restarts, step && last_byte, (phase_q == PH_HEADER) && (hidx_q == 3'd0) && (cnt_q == 16'd0), "last byte did not restart parser")
	`TRHP_ASSERT_IMP(a_body_below_len, phase_q == PH_BODY, cnt_q < len_q, "body count reached length without finishing")
	`TRHP_ASSERT_IMP(a_fail_zero, step && res_fire && (res.status != ST_OK), (res.fragment_length == 16'd0) && (res.bytes_consumed == 17'd0) && (res.content_type == 8'd0), "failed result carries header fields")
	`TRHP_ASSERT_IMP(a_ok_consumed, step && res_fire && (res.status == ST_OK), (res.bytes_consumed == {1'b0, res.fragment_length} + 17'd5) && (res.fragment_length <= max_len), "success result inconsistent")

endmodule

`default_nettype wire

FILE: hdl/tls_record_header_parser.sv
// TLS record header parser, top level: input stage, output stage, config register.
// Depends on trhp_pkg and trhp_core.
//
// Usage:
//  - in channel: one receive-buffer byte per beat (data_byte), last_byte set on
//    the final byte of the buffer. Each buffer yields exactly one result beat.
//  - out channel: status (0 ok, 1 more data needed, 2 invalid) and, on ok, the
//    header fields, fragment_length and bytes_consumed (5 + fragment_length).
//    A result beat comes on the byte that decides it; bytes after it up to the
//    last flag are dropped without a result.
//  - cfg channel: cfg_data sets max_fragment_length; always ready. Write only
//    while the parser is idle.
// Timing: a byte is registered on acceptance, decided by one level of logic and
//   its result registered; a result beat is valid once the core has stepped on
//   its byte and the result stage has taken it. Throughput is one byte per cycle
//   without result stalls, set by the single state update per byte in trhp_core.
// Stall: when out_ready is low with a result waiting, the input stage holds and
//   in_ready drops once that stage is full; no beat is lost or repeated.
// Reset: arst_n clears both stages, returns the parser to the header phase and
//   loads max_fragment_length with 18432.
`default_nettype none

module tls_record_header_parser
	import trhp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input byte channel
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   data_byte,
	input  wire logic         last_byte,
	// result channel
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [1:0]        status,
	output logic [7:0]        content_type,
	output logic [7:0]        version_major,
	output logic [7:0]        version_minor,
	output logic [15:0]       fragment_length,
	output logic [16:0]       bytes_consumed,
	// config write channel
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [15:0]  cfg_data
);

	// input stage
	logic         v_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;

	// result stage
	logic         v_s2;
	trhp_result_t res_s2;

	logic [15:0]  max_len_q;
	logic         adv;
	logic         step;
	logic         res_fire;
	trhp_result_t res;

	// result stage can take a new value when empty or being drained
	assign adv       = !v_s2 || out_ready;
	assign step      = v_s1 && adv;
	assign in_ready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_FRAG_RST;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	trhp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.max_len   (max_len_q),
		.res       (res),
		.res_fire  (res_fire)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= step && res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = v_s2;
	assign status          = res_s2.status;
	assign content_type    = res_s2.content_type;
	assign version_major   = res_s2.version_major;
	assign version_minor   = res_s2.version_minor;
	assign fragment_length = res_s2.fragment_length;
	assign bytes_consumed  = res_s2.bytes_consumed;

endmodule

`default_nettype wire

FILE: tb/trhp_result_checker.sv
// Result checker for the TLS record header parser testbench.
// Watches the byte, result and config channels of the parser; depends on trhp_pkg.
// Predicts one verdict per buffer and compares each result beat against it.
module trhp_result_checker
	import trhp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic [7:0]         content_type,
	input  logic [7:0]         version_major,
	input  logic [7:0]         version_minor,
	input  logic [15:0]        fragment_length,
	input  logic [16:0]        bytes_consumed,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output int unsigned        fail_count,
	output int unsigned        pending
);

	typedef enum logic [1:0] {SCAN_HEADER, SCAN_BODY, SCAN_DRAIN} scan_state_t;

	scan_state_t   scan_state;
	logic [2:0]    hdr_pos;
	logic [7:0]    rec_type;
	logic [7:0]    rec_major;
	logic [7:0]    rec_minor;
	logic [15:0]   rec_length;
	logic [15:0]   body_seen;
	logic [15:0]   frag_limit;
	trhp_result_t  predicted_verdicts[$];

	// Advance the parse by one byte; queue a verdict when this byte decides one.
	task automatic parse_rx_byte(input logic [7:0] b, input logic is_last);
		trhp_result_t verdict;
		logic         decided;
		verdict = '0;
		decided = 1'b0;
		case (scan_state)
			SCAN_HEADER: begin
				case (hdr_pos)
					3'd0: rec_type = b;
					3'd1: rec_major = b;
					3'd2: rec_minor = b;
					3'd3: rec_length = {b, 8'h00};
					default: rec_length[7:0] = b;
				endcase
				hdr_pos = hdr_pos + 3'd1;
				if (hdr_pos < HDR_BYTES) begin
					if (is_last) begin
						verdict.status = ST_MORE;
						decided = 1'b1;
					end
				end else if (rec_type < TYPE_MIN || rec_type > TYPE_MAX ||
						rec_major != VER_MAJOR || rec_minor < MINOR_MIN ||
						rec_minor > MINOR_MAX || rec_length > frag_limit) begin
					verdict.status = ST_BAD;
					decided = 1'b1;
				end else if (rec_length == 16'd0) begin
					decided = 1'b1;
				end else if (is_last) begin
					verdict.status = ST_MORE;
					decided = 1'b1;
				end else begin
					scan_state = SCAN_BODY;
					body_seen = '0;
				end
			end
			SCAN_BODY: begin
				body_seen = body_seen + 16'd1;
				if (body_seen == rec_length) begin
					decided = 1'b1;
				end else if (is_last) begin
					verdict.status = ST_MORE;
					decided = 1'b1;
				end
			end
			default: ;
		endcase
		if (decided) begin
			// header fields only travel with a success
			if (verdict.status == ST_OK) begin
				verdict.content_type = rec_type;
				verdict.version_major = rec_major;
				verdict.version_minor = rec_minor;
				verdict.fragment_length = rec_length;
				verdict.bytes_consumed = 17'(rec_length) + 17'(HDR_BYTES);
			end
			predicted_verdicts.push_back(verdict);
			scan_state = SCAN_DRAIN;
		end
		if (is_last) begin
			scan_state = SCAN_HEADER;
			hdr_pos = '0;
			body_seen = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		trhp_result_t got;
		trhp_result_t want;
		if (!arst_n) begin
			scan_state = SCAN_HEADER;
			hdr_pos = '0;
			rec_type = '0;
			rec_major = '0;
			rec_minor = '0;
			rec_length = '0;
			body_seen = '0;
			frag_limit = MAX_FRAG_RST;
			predicted_verdicts.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				frag_limit = cfg_data;
			if (in_valid && in_ready)
				parse_rx_byte(data_byte, last_byte);
			if (out_valid && out_ready) begin
				got = {status, content_type, version_major, version_minor,
					fragment_length, bytes_consumed};
				if (predicted_verdicts.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: status %0d type %0d len %0d",
							status, content_type, fragment_length);
				end else begin
					want = predicted_verdicts.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("result mismatch: exp st %0d ty %0d ver %0d.%0d len %0d used %0d",
								want.status, want.content_type, want.version_major,
								want.version_minor, want.fragment_length,
								want.bytes_consumed);
							$display(" / got st %0d ty %0d ver %0d.%0d len %0d used %0d",
								got.status, got.content_type,
								got.version_major, got.version_minor,
								got.fragment_length, got.bytes_consumed);
						end
					end
				end
			end
			pending = predicted_verdicts.size();
		end
	end

endmodule

FILE: tb/tls_record_header_parser_tb.sv
// Testbench top for tls_record_header_parser: clock, reset, stimulus and verdict.
// Depends on trhp_pkg, tls_record_header_parser and trhp_result_checker.
// Buffers are mostly well-formed records with random content, plus broken ones.
module tls_record_header_parser_tb
	import trhp_pkg::*;
();

	// Timeout for the whole run of about 1300 bytes, with input gaps,
	// result stalls, the long hold and the drains.
	localparam int unsigned LIMIT_CYCLES = 100_000;
	// Long receiver hold used to back the parser up into its input stage.
	localparam int unsigned HOLD_CYCLES  = 80;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         in_valid;
	logic         in_ready;
	logic [7:0]   data_byte;
	logic         last_byte;
	logic         out_valid;
	logic         out_ready;
	logic [1:0]   status;
	logic [7:0]   content_type;
	logic [7:0]   version_major;
	logic [7:0]   version_minor;
	logic [15:0]  fragment_length;
	logic [16:0]  bytes_consumed;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	int unsigned  fail_count;
	int unsigned  pending;
	int unsigned  cycle_count = 0;

	// Stimulus-side copy of max_fragment_length, used to aim lengths at the limit.
	logic [15:0]  frag_limit;
	bit           idle_on;
	bit           hold_req;

	tls_record_header_parser dut (.*);

	trhp_result_checker result_chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog; a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side. Random stall bursts while idle_on is set,
	// plus one long hold on request, counted here.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One beat on the byte channel; valid stays up across back-to-back beats.
	// A gap, when taken, drops valid before the beat.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= is_last;
		do @(posedge clk); while (!in_ready);
	endtask

	// Sends one buffer of nbytes: a 5-byte header, then random fragment and
	// trailing bytes. nbytes below 5 + flen cuts the record short.
	task automatic send_record(input logic [7:0] ctype, input logic [7:0] vmaj,
			input logic [7:0] vmin, input logic [15:0] flen, input int unsigned nbytes);
		logic [7:0] b;
		for (int unsigned i = 0; i < nbytes; i++) begin
			case (i)
				0: b = ctype;
				1: b = vmaj;
				2: b = vmin;
				3: b = flen[15:8];
				4: b = flen[7:0];
				default: b = 8'($urandom);
			endcase
			send_byte(b, i == nbytes - 1);
		end
	endtask

	// Random buffer: mostly plausible headers, some broken, some pure noise.
	task automatic send_random_buffer(output int unsigned nbytes);
		logic [7:0]  ctype;
		logic [7:0]  vmaj;
		logic [7:0]  vmin;
		logic [15:0] flen;
		int unsigned full_len;
		ctype = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(20, 23)) :
			($urandom_range(0, 1) ? 8'($urandom_range(18, 25)) : 8'($urandom));
		vmaj = ($urandom_range(0, 9) < 9) ? 8'd3 : 8'($urandom);
		vmin = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 3)) :
			($urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom));
		case ($urandom_range(0, 9))
			0: flen = '0;
			// right at the limit, only when it is cheap to send
			7: flen = (frag_limit <= 16'd300) ? frag_limit : 16'($urandom_range(0, 24));
			// one past the limit
			8: flen = (frag_limit != 16'hFFFF) ? frag_limit + 16'd1 :
				16'($urandom_range(0, 24));
			9: begin
				flen = 16'($urandom);
				if (flen <= frag_limit && flen > 16'd300)
					flen = flen % 16'd25;
			end
			default: flen = 16'($urandom_range(0, 24));
		endcase
		full_len = 5 + flen;
		// anything longer is rejected at the header; no point sending the body
		if (full_len > 310)
			full_len = 5 + $urandom_range(0, 8);
		if ($urandom_range(0, 9) < 7)
			nbytes = full_len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
		else
			nbytes = $urandom_range(1, full_len);
		if ($urandom_range(0, 99) < 8) begin
			ctype = 8'($urandom);
			vmaj = 8'($urandom);
			vmin = 8'($urandom);
			flen = 16'($urandom);
			nbytes = $urandom_range(1, 12);
		end
		send_record(ctype, vmaj, vmin, flen, nbytes);
	endtask

	task automatic send_random_bytes(input int unsigned target);
		int unsigned sent;
		int unsigned n;
		sent = 0;
		while (sent < target) begin
			send_random_buffer(n);
			sent += n;
		end
	endtask

	// Drop valid, then wait for every predicted result plus the pipeline depth.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_frag_limit(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		frag_limit = v;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		frag_limit = MAX_FRAG_RST;
		idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed buffers under the reset limit.
		send_record(8'd20, 8'd3, 8'd1, 16'd0, 5);          // empty fragment, ok
		send_record(8'd23, 8'd3, 8'd3, 16'd0, 8);          // ok, then trailing bytes dropped
		send_record(8'd23, 8'd3, 8'd1, 16'd0, 1);          // ends after one byte
		send_record(8'd0, 8'd0, 8'd0, 16'd0, 4);           // ends inside the header
		send_record(8'd19, 8'd3, 8'd1, 16'd0, 5);          // type just below range
		send_record(8'd24, 8'd3, 8'd2, 16'd0, 7);          // type just above, then skip
		send_record(8'd21, 8'd2, 8'd1, 16'd0, 5);          // wrong major
		send_record(8'd22, 8'd3, 8'd0, 16'd0, 5);          // minor below range
		send_record(8'd22, 8'd3, 8'd4, 16'd0, 5);          // minor above range
		send_record(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 5);     // all ones
		send_record(8'd20, 8'd3, 8'd1, MAX_FRAG_RST + 16'd1, 5); // one over the limit
		send_record(8'd23, 8'd3, 8'd1, MAX_FRAG_RST, 5);   // at the limit, body missing
		send_record(8'd22, 8'd3, 8'd2, 16'd3, 8);          // short body, ok on its last byte
		send_record(8'd20, 8'd3, 8'd2, 16'd6, 8);          // ends mid body
		wait_drained();

		// Limit 0: only empty fragments pass.
		write_frag_limit(16'd0);
		send_random_bytes(150);
		wait_drained();

		// Widest limit: the largest length passes the header checks.
		write_frag_limit(16'hFFFF);
		send_record(8'd23, 8'd3, 8'd3, 16'hFFFF, 5);       // at the limit, body missing
		send_random_bytes(200);

		// Back up the parser: receiver holds while records keep coming.
		hold_req = 1'b1;
		repeat (8) send_record(8'd21, 8'd3, 8'd2, 16'd0, 5);
		wait_drained();

		// Small limits put lengths right at and just past the edge.
		write_frag_limit(16'($urandom_range(20, 200)));
		send_random_bytes(300);
		wait_drained();

		write_frag_limit(16'($urandom));
		send_random_bytes(200);
		wait_drained();

		// Final stretch at full rate on both sides.
		write_frag_limit(MAX_FRAG_RST);
		idle_on = 1'b0;
		send_random_bytes(250);
		wait_drained();
		repeat (10) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
